// ----- hw/rtl/tournament_branch_predictor_defines.svh -----
// Assertion macros for the branch predictor port checker.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_DEFINES_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define TBP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that also holds while reset is applied.
`define TBP_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/tbp_pkg.sv -----
// Shared constants, types and helpers of the tournament branch predictor.
`default_nettype none

package tbp_pkg;

    // Table geometry
    localparam int GHIST_BITS    = 9;
    localparam int LHIST_BITS    = 10;
    localparam int PC_INDEX_BITS = 10;

    localparam int GHIST_SIZE = 1 << GHIST_BITS;
    localparam int LHIST_SIZE = 1 << LHIST_BITS;
    localparam int PCIDX_SIZE = 1 << PC_INDEX_BITS;

    // Sweep index covers the deepest table
    localparam int CLR_BITS =
        (PC_INDEX_BITS > LHIST_BITS) ?
            ((PC_INDEX_BITS > GHIST_BITS) ? PC_INDEX_BITS : GHIST_BITS) :
            ((LHIST_BITS > GHIST_BITS) ? LHIST_BITS : GHIST_BITS);

    // Two-bit saturating counter codes
    localparam logic [1:0] CTR_MAX         = 2'd3;
    localparam logic [1:0] CTR_MIN         = 2'd0;
    localparam logic [1:0] CTR_WEAK_NT     = 2'd1;
    localparam logic [1:0] CTR_WEAK_GLOBAL = 2'd2;

    // Input and result queues (depth must be a power of two)
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    // Decoded item handed from the front end to the engine
    typedef struct packed {
        logic                     train;
        logic [PC_INDEX_BITS-1:0] pc_idx;
        logic                     taken;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } fe_cmd_t;

    // Engine sequencer
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } eng_state_t;

    // One saturating step of a two-bit counter
    function automatic logic [1:0] sat_step(input logic [1:0] ctr, input logic up);
        logic [1:0] res;
        if (up) begin
            res = (ctr == CTR_MAX) ? CTR_MAX : ctr + 2'd1;
        end
        else begin
            res = (ctr == CTR_MIN) ? CTR_MIN : ctr - 2'd1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tbp_front.sv -----
// Front end: accepts items, decodes them and buffers them for the engine.
`default_nettype none

module tbp_front
    import tbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        mode,
    input  wire logic [31:0] pc,
    input  wire logic        outcome,
    input  wire logic        clearing,
    output fe_cmd_t          cmd_out,
    input  wire logic        cmd_ready
);

    cmd_t                  q_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  accept;
    logic                  take;
    cmd_t                  decoded;

    // No items while the tables are being swept
    assign full   = (cnt_reg == Q_CNT_BITS'(Q_DEPTH)) || clearing;
    assign accept = push && !full;
    assign take   = cmd_ready && cmd_out.valid;

    // Classify: keep index bits only, outcome matters only for training
    always_comb
    begin
        decoded.train  = mode;
        decoded.pc_idx = pc[PC_INDEX_BITS-1:0];
        decoded.taken  = outcome & mode;
    end

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = accept ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + Q_CNT_BITS'(accept) - Q_CNT_BITS'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

    assign cmd_out.valid = (cnt_reg != '0);
    assign cmd_out.cmd   = q_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ----- hw/rtl/tbp_back.sv -----
// Engine: holds the predictor tables, looks up, predicts and trains.
`default_nettype none

module tbp_back
    import tbp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire fe_cmd_t cmd_in,
    output logic         cmd_ready,
    output logic         clearing,
    input  wire logic    res_full,
    output logic         res_push,
    output logic         res_taken
);

    // Tables
    logic [LHIST_BITS-1:0] lht_mem  [PCIDX_SIZE];
    logic [1:0]            lctr_mem [LHIST_SIZE];
    logic [1:0]            gctr_mem [GHIST_SIZE];
    logic [1:0]            ch_mem   [GHIST_SIZE];

    eng_state_t            state_reg, state_next;
    logic [CLR_BITS-1:0]   clr_reg;
    logic [GHIST_BITS-1:0] ghist_reg;
    cmd_t                  cmd_reg;

    logic [LHIST_BITS-1:0] lht_q_reg;
    logic [1:0]            lctr_q_reg;
    logic [1:0]            gctr_q_reg;
    logic [1:0]            ch_q_reg;

    logic                  clr_we;
    logic                  rd_a_en;
    logic                  rd_l_en;
    logic                  upd_en;
    logic                  clr_last;

    logic                  l_pred;
    logic                  g_pred;
    logic                  ch_we;
    logic [LHIST_BITS:0]   lht_shift;
    logic [GHIST_BITS:0]   ghist_shift;

    assign clr_last = (clr_reg == '1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_in.valid && !res_full)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        clr_we    = 1'b0;
        cmd_ready = 1'b0;
        rd_a_en   = 1'b0;
        rd_l_en   = 1'b0;
        res_push  = 1'b0;
        upd_en    = 1'b0;
        case (state_reg)
            ST_CLEAR:  clr_we = 1'b1;
            ST_IDLE:
            begin
                if (cmd_in.valid && !res_full)
                begin
                    cmd_ready = 1'b1;
                    rd_a_en   = 1'b1;
                end
            end
            ST_LOOKUP: rd_l_en = 1'b1;
            ST_UPDATE:
            begin
                res_push = 1'b1;
                upd_en   = cmd_reg.train;
            end
            default:   clr_we = 1'b0;
        endcase
    end

    assign clearing = (state_reg == ST_CLEAR);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ghist_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_we)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (upd_en)
            begin
                ghist_reg <= ghist_shift[GHIST_BITS-1:0];
            end
        end
    end

    // Item under work
    always_ff @(posedge clk)
    begin
        if (cmd_ready)
        begin
            cmd_reg <= cmd_in.cmd;
        end
    end

    // Prediction and training values
    assign l_pred      = lctr_q_reg[1];
    assign g_pred      = gctr_q_reg[1];
    assign res_taken   = ch_q_reg[1] ? g_pred : l_pred;
    assign ch_we       = upd_en && (l_pred != g_pred);
    assign lht_shift   = {lht_q_reg, cmd_reg.taken};
    assign ghist_shift = {ghist_reg, cmd_reg.taken};

    // Local history table
    always_ff @(posedge clk)
    begin
        if (clr_we)
        begin
            lht_mem[clr_reg[PC_INDEX_BITS-1:0]] <= '0;
        end
        else if (upd_en)
        begin
            lht_mem[cmd_reg.pc_idx] <= lht_shift[LHIST_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_a_en)
        begin
            lht_q_reg <= lht_mem[cmd_in.cmd.pc_idx];
        end
    end

    // Local counters, addressed by the history just read
    always_ff @(posedge clk)
    begin
        if (clr_we)
        begin
            lctr_mem[clr_reg[LHIST_BITS-1:0]] <= CTR_WEAK_NT;
        end
        else if (upd_en)
        begin
            lctr_mem[lht_q_reg] <= sat_step(lctr_q_reg, cmd_reg.taken);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_l_en)
        begin
            lctr_q_reg <= lctr_mem[lht_q_reg];
        end
    end

    // Global counters
    always_ff @(posedge clk)
    begin
        if (clr_we)
        begin
            gctr_mem[clr_reg[GHIST_BITS-1:0]] <= CTR_WEAK_NT;
        end
        else if (upd_en)
        begin
            gctr_mem[ghist_reg] <= sat_step(gctr_q_reg, cmd_reg.taken);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_a_en)
        begin
            gctr_q_reg <= gctr_mem[ghist_reg];
        end
    end

    // Chooser: moves only when the components disagree
    always_ff @(posedge clk)
    begin
        if (clr_we)
        begin
            ch_mem[clr_reg[GHIST_BITS-1:0]] <= CTR_WEAK_GLOBAL;
        end
        else if (ch_we)
        begin
            ch_mem[ghist_reg] <= sat_step(ch_q_reg, g_pred == cmd_reg.taken);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_a_en)
        begin
            ch_q_reg <= ch_mem[ghist_reg];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tbp_res_q.sv -----
// Result queue: holds predictions until the receiver pops them.
`default_nettype none

module tbp_res_q
    import tbp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic res_push,
    input  wire logic res_taken,
    output logic      res_full,
    output logic      empty,
    input  wire logic pop,
    output logic      predict_taken
);

    logic                  q_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  take;

    assign res_full = (cnt_reg == Q_CNT_BITS'(Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign take     = pop && !empty;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = res_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + Q_CNT_BITS'(res_push) - Q_CNT_BITS'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            q_reg[wr_ptr_reg] <= res_taken;
        end
    end

    assign predict_taken = q_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ----- hw/rtl/tournament_branch_predictor.sv -----
// Top level of the tournament (local, global, chooser) branch predictor.
//
// Input channel is a queue: an item (mode, pc, outcome) is taken on a rising
// edge with push high and full low. mode 0 only predicts; mode 1 also trains
// the tables with outcome. Only the low index bits of pc are used.
// Result channel is a queue: while empty is low, predict_taken shows the
// oldest prediction, taken on a rising edge with pop high. Every item gives
// exactly one result, the chosen direction before any training.
// One item at a time: the engine takes a new item only after the dependent
// steps of the last: the local history read, then the local counter read
// addressed by it, then the write-back that the next item's reads must see.
// The engine takes an item, reads in lookup and queues the result in update.
// A two-entry queue on each side lets the sender and receiver stall
// independently; with the result queue full the engine holds its next item
// and full rises once the input queue fills.
// Reset: histories are cleared and a sweep writes the counter tables to
// their reset values; full stays high throughout.
`default_nettype none

module tournament_branch_predictor
    import tbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        mode,
    input  wire logic [31:0] pc,
    input  wire logic        outcome,
    output logic             empty,
    input  wire logic        pop,
    output logic             predict_taken
);

    fe_cmd_t fe_cmd;
    logic    cmd_ready;
    logic    clearing;
    logic    res_full;
    logic    res_push;
    logic    res_taken;

    // Item intake and decode
    tbp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .pc        (pc),
        .outcome   (outcome),
        .clearing  (clearing),
        .cmd_out   (fe_cmd),
        .cmd_ready (cmd_ready)
    );

    // Table lookup and training
    tbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_in    (fe_cmd),
        .cmd_ready (cmd_ready),
        .clearing  (clearing),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_taken (res_taken)
    );

    // Result buffering
    tbp_res_q u_res_q (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_push      (res_push),
        .res_taken     (res_taken),
        .res_full      (res_full),
        .empty         (empty),
        .pop           (pop),
        .predict_taken (predict_taken)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/tbp_checker.sv -----
// Port-level checker for the branch predictor, bound to the top level.
`default_nettype none
`include "tournament_branch_predictor_defines.svh"

module tbp_port_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic push,
    input wire logic full,
    input wire logic empty,
    input wire logic pop,
    input wire logic predict_taken
);

    // A waiting result stays put until it is popped
    `TBP_ASSERT(a_res_hold, !empty && !pop |=> !empty && $stable(predict_taken), "result moved")

    // Nothing waits on the result side during reset
    `TBP_ASSERT_RST(a_rst_empty, !rst_n |-> empty, "result shown during reset")

    // Intake is closed during reset
    `TBP_ASSERT_RST(a_rst_full, !rst_n |-> full, "input open during reset")

    // The table sweep keeps intake closed just after reset
    `TBP_ASSERT_RST(a_sweep_full, !rst_n |=> full, "input open before table sweep")

    // An item is accepted only outside reset
    `TBP_ASSERT(a_push_seen, push && !full |-> rst_n, "item accepted in reset")

endmodule

bind tournament_branch_predictor tbp_port_checker u_tbp_checker (.*);

`default_nettype wire

// ----- dv/tbp_checker.sv -----
// Checker for the tournament branch predictor: tracks the tables and scores each result.
module tbp_checker
    import tbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        mode,
    input  logic [31:0] pc,
    input  logic        outcome,
    input  logic        empty,
    input  logic        pop,
    input  logic        predict_taken,
    output int          errors,
    output int          pending
);

    // Shadow copy of the predictor tables
    logic [GHIST_BITS-1:0] ghist;
    logic [LHIST_BITS-1:0] lhist_tab  [PCIDX_SIZE];
    logic [1:0]            local_ctr  [LHIST_SIZE];
    logic [1:0]            global_ctr [GHIST_SIZE];
    logic [1:0]            choice_ctr [GHIST_SIZE];

    // Predicted directions still waiting for the block to deliver them
    logic                  dir_q [$];
    int                    fail_count;

    // One saturating move of a two-bit counter
    function automatic logic [1:0] ctr_nudge(input logic [1:0] c, input logic up);
        logic [1:0] r;
        r = c;
        if (up && c != CTR_MAX)
            r = c + 2'd1;
        else if (!up && c != 2'd0)
            r = c - 2'd1;
        return r;
    endfunction

    // Work out the chosen direction of one item, then train if asked
    task automatic lookup_and_train(input logic train, input logic [31:0] addr,
                                    input logic taken);
        logic [PC_INDEX_BITS-1:0] row;
        logic [GHIST_BITS-1:0]    gi;
        logic [LHIST_BITS-1:0]    lh;
        logic [1:0]               lc;
        logic [1:0]               gc;
        logic [1:0]               ch;
        logic                     l_dir;
        logic                     g_dir;
        row   = addr[PC_INDEX_BITS-1:0];
        gi    = ghist;
        lh    = lhist_tab[row];
        lc    = local_ctr[lh];
        gc    = global_ctr[gi];
        ch    = choice_ctr[gi];
        l_dir = lc[1];
        g_dir = gc[1];
        dir_q.push_back(ch[1] ? g_dir : l_dir);
        if (train) begin
            // chooser only moves when the two sides disagree
            if (l_dir != g_dir)
                choice_ctr[gi] = ctr_nudge(ch, g_dir == taken);
            local_ctr[lh]  = ctr_nudge(lc, taken);
            global_ctr[gi] = ctr_nudge(gc, taken);
            lhist_tab[row] = {lh[LHIST_BITS-2:0], taken};
            ghist          = {gi[GHIST_BITS-2:0], taken};
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        logic want;
        if (!rst_n) begin
            ghist = '0;
            for (int i = 0; i < PCIDX_SIZE; i++)
                lhist_tab[i] = '0;
            for (int i = 0; i < LHIST_SIZE; i++)
                local_ctr[i] = CTR_WEAK_NT;
            for (int i = 0; i < GHIST_SIZE; i++)
            begin
                global_ctr[i] = CTR_WEAK_NT;
                choice_ctr[i] = CTR_WEAK_GLOBAL;
            end
            dir_q.delete();
            fail_count = 0;
            errors  <= 0;
            pending <= 0;
        end
        else begin
            // score the result leaving the block
            if (pop && !empty) begin
                if (dir_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual predict_taken=%0b",
                             $time, predict_taken);
                end
                else begin
                    want = dir_q.pop_front();
                    if (predict_taken !== want) begin
                        fail_count++;
                        $display("%0t: predict_taken mismatch, expected %0b, actual %0b",
                                 $time, want, predict_taken);
                    end
                end
            end
            // item entering the block
            if (push && !full)
                lookup_and_train(mode, pc, outcome);
            errors  <= fail_count;
            pending <= dir_q.size();
        end
    end

endmodule

// ----- dv/tb_tournament_branch_predictor.sv -----
// Testbench top for the tournament branch predictor: stimulus, receiver and verdict.
module tb_tournament_branch_predictor
    import tbp_pkg::*;
();

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        mode;
    logic [31:0] pc;
    logic        outcome;
    logic        empty;
    logic        pop;
    logic        predict_taken;
    int          errors;
    int          pending;

    // Sender pacing and pressure requests
    int          burst_left;
    bit          hold_req;

    // Loop branches used by the random part: index, outcome pattern, period
    logic [PC_INDEX_BITS-1:0] loop_row    [8];
    logic [7:0]               loop_pat    [8];
    int                       loop_period [8];
    int                       loop_iter   [8];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    tournament_branch_predictor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .mode          (mode),
        .pc            (pc),
        .outcome       (outcome),
        .empty         (empty),
        .pop           (pop),
        .predict_taken (predict_taken)
    );

    tbp_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .mode          (mode),
        .pc            (pc),
        .outcome       (outcome),
        .empty         (empty),
        .pop           (pop),
        .predict_taken (predict_taken),
        .errors        (errors),
        .pending       (pending)
    );

    // Offer one item; bursts keep push high, a random gap precedes each burst
    task automatic offer(input logic m, input logic [31:0] p, input logic o);
        int gap;
        if (burst_left == 0) begin
            @(negedge clk) push <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 16);
        end
        @(negedge clk);
        push    <= 1'b1;
        mode    <= m;
        pc      <= p;
        outcome <= o;
        do
            @(posedge clk);
        while (full);
        burst_left--;
    endtask

    // Stop sending until every predicted result has come back
    task automatic drain_results();
        @(negedge clk) push <= 1'b0;
        wait (pending == 0);
        burst_left = 0;
    endtask

    // New loop branches so that the chooser has to change its mind
    task automatic shuffle_loops();
        for (int i = 0; i < 8; i++)
        begin
            loop_row[i]    = PC_INDEX_BITS'($urandom);
            loop_pat[i]    = 8'($urandom);
            loop_period[i] = $urandom_range(1, 8);
            loop_iter[i]   = 0;
        end
    endtask

    // Receiver: stretches of steady, random and sparse popping, one long hold-off
    initial
    begin
        int  stretch;
        int  style;
        bit  held;
        pop  = 1'b0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !held) begin
                held = 1'b1;
                for (int i = 0; i < 400; i++)
                begin
                    @(negedge clk) pop <= 1'b0;
                end
            end
            style   = $urandom_range(0, 2);
            stretch = $urandom_range(1, 40);
            for (int i = 0; i < stretch; i++)
            begin
                @(negedge clk);
                case (style)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    default: pop <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Time limit
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        int          s;
        int          r;
        logic [31:0] p;
        logic        o;
        push       = 1'b0;
        mode       = 1'b0;
        pc         = '0;
        outcome    = 1'b0;
        rst_n      = 1'b0;
        hold_req   = 1'b0;
        burst_left = 0;
        shuffle_loops();
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed: predict only with the outcome ignored, pc extremes,
        // saturation on one branch, aliasing through the high pc bits
        offer(1'b0, 32'h0000_0000, 1'b1);
        offer(1'b0, 32'hFFFF_FFFF, 1'b0);
        repeat (4) offer(1'b1, 32'h0000_0000, 1'b1);
        offer(1'b0, 32'hFFFF_FC00, 1'b1);
        offer(1'b1, 32'hFFFF_FC00, 1'b1);
        repeat (4) offer(1'b1, 32'hFFFF_FFFF, 1'b0);
        offer(1'b0, 32'h0000_03FF, 1'b1);
        for (int i = 0; i < 4; i++)
            offer(1'b1, 32'h0000_0155, i[0]);
        offer(1'b0, 32'hAAAA_AAAA, 1'b0);
        offer(1'b0, 32'h5555_5555, 1'b1);
        offer(1'b1, 32'h8000_0000, 1'b1);
        offer(1'b1, 32'h0000_03FF, 1'b0);
        offer(1'b0, 32'h0000_0000, 1'b0);
        drain_results();

        // Random: mostly trained loop branches, some noise
        for (int n = 0; n < 650; n++)
        begin
            if (n == 150)
                hold_req = 1'b1;
            if (n == 350)
                drain_results();
            if (n > 0 && n % 200 == 0)
                shuffle_loops();
            r = $urandom_range(0, 99);
            s = $urandom_range(0, 7);
            p = $urandom;
            if (r < 80)
                p[PC_INDEX_BITS-1:0] = loop_row[s];
            if (r < 65) begin
                o = loop_pat[s][loop_iter[s] % loop_period[s]];
                loop_iter[s]++;
                offer(1'b1, p, o);
            end
            else if (r < 80)
                offer(1'b0, p, 1'($urandom_range(0, 1)));
            else if (r < 92)
                offer(1'b1, p, 1'($urandom_range(0, 1)));
            else
                offer(1'b0, p, 1'($urandom_range(0, 1)));
        end

        // Let the last results out, then settle
        @(negedge clk) push <= 1'b0;
        wait (pending == 0);
        repeat (16) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/tbp_pkg.sv
hw/rtl/tbp_front.sv
hw/rtl/tbp_back.sv
hw/rtl/tbp_res_q.sv
hw/rtl/tournament_branch_predictor.sv
hw/rtl/tbp_checker.sv
dv/tbp_checker.sv
dv/tb_tournament_branch_predictor.sv
